### hw/rtl/srec_line_checker_defines.svh
// assertion macros shared by the checker rtl
`ifndef SREC_LINE_CHECKER_DEFINES_SVH
`define SREC_LINE_CHECKER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define SREC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define SREC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/srec_pkg.sv
package srec_pkg;

  localparam int CHAR_W = 8;
  localparam int LINE_W = 16;
  localparam int POS_W  = 10;

  localparam logic [POS_W-1:0] POS_MAX = 10'd1023;

  // characters
  localparam logic [CHAR_W-1:0] CH_S       = 8'h53;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_ONE     = 8'h31;
  localparam logic [CHAR_W-1:0] CH_TWO     = 8'h32;
  localparam logic [CHAR_W-1:0] CH_THREE   = 8'h33;
  localparam logic [CHAR_W-1:0] CH_FIVE    = 8'h35;
  localparam logic [CHAR_W-1:0] CH_SIX     = 8'h36;
  localparam logic [CHAR_W-1:0] CH_SEVEN   = 8'h37;
  localparam logic [CHAR_W-1:0] CH_EIGHT   = 8'h38;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_F = 8'h46;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_F = 8'h66;

  // subtracting these leaves the digit value in the low nibble
  localparam logic [CHAR_W-1:0] HEX_UC_OFS = 8'h37;
  localparam logic [CHAR_W-1:0] HEX_LC_OFS = 8'h57;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_START      = 3'd1,
    ST_TYPE       = 3'd2,
    ST_BYTE_COUNT = 3'd3,
    ST_HEX        = 3'd4,
    ST_CHECKSUM   = 3'd5,
    ST_LINE_COUNT = 3'd6,
    ST_CONFLICT   = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    FAM_S19 = 2'd0,
    FAM_S28 = 2'd1,
    FAM_S37 = 2'd2
  } fam_t;

  // everything the end-of-line check looks at
  typedef struct packed {
    logic              start_ok;
    logic              cnt_bad;
    logic              pair_bad;
    logic [CHAR_W-1:0] type_char;
    logic [POS_W-1:0]  char_pos;
    logic [7:0]        declared;
    logic [7:0]        byte_sum;
    logic [7:0]        last_byte;
    logic [LINE_W-1:0] count_field;
    logic [LINE_W-1:0] line;
    logic [LINE_W-1:0] tally;
    fam_t              family;
  } line_info_t;

  // verdict plus updates to the cross-line state
  typedef struct packed {
    status_t status;
    logic    family_we;
    fam_t    family;
    logic    tally_inc;
  } line_verdict_t;

endpackage

### hw/rtl/srec_status.sv
module srec_status (
  input  srec_pkg::line_info_t    info,
  output srec_pkg::line_verdict_t verdict
);
  import srec_pkg::*;

  logic [LINE_W-1:0] expect_cnt;
  status_t           rel;
  fam_t              cur;

  assign expect_cnt = info.line - 16'd1 - info.tally;

  // start check, then record type, family and line count checks, then the byte level checks
  always_comb begin
    rel               = ST_OK;
    cur               = FAM_S19;
    verdict.status    = ST_OK;
    verdict.family_we = 1'b0;
    verdict.family    = info.family;
    verdict.tally_inc = 1'b0;
    if (!info.start_ok) begin
      verdict.status = ST_START;
    end else begin
      if (info.line == '0) begin
        if (info.type_char != CH_ZERO) rel = ST_TYPE;
      end else begin
        case (info.type_char)
          CH_ONE, CH_NINE:    cur = FAM_S19;
          CH_TWO, CH_EIGHT:   cur = FAM_S28;
          CH_THREE, CH_SEVEN: cur = FAM_S37;
          CH_FIVE, CH_SIX: begin
            if (info.count_field != expect_cnt) rel = ST_LINE_COUNT;
            verdict.tally_inc = 1'b1;
            cur = info.family;
          end
          default: begin
            rel = ST_TYPE;
            cur = FAM_S19;
          end
        endcase
        if (info.line > 16'd1 && cur != info.family) begin
          rel = ST_CONFLICT;
        end else begin
          verdict.family_we = 1'b1;
          verdict.family    = cur;
        end
      end
      if (rel != ST_OK) begin
        verdict.status = rel;
      end else if (info.char_pos < 10'd4 || info.cnt_bad) begin
        verdict.status = ST_HEX;
      end else if ((info.char_pos - 10'd4) != {1'b0, info.declared, 1'b0}) begin
        verdict.status = ST_BYTE_COUNT;
      end else if (info.pair_bad) begin
        verdict.status = ST_HEX;
      end else if (info.last_byte != ~info.byte_sum) begin
        verdict.status = ST_CHECKSUM;
      end else begin
        verdict.status = ST_OK;
      end
    end
  end

endmodule

### hw/rtl/srec_line_checker.sv
// A character is registered in the input register when its request is taken; a carriage
// return's result is then registered on the out_ register once that register is free.
// Throughput: one character per cycle. A carriage return waits in the input register
// only while the result register still holds an untaken result.
// Reset (rst_n low, synchronous): line index, S5/S6 tally and family (S19) and the
// current line state clear; both valids drop.
`include "srec_line_checker_defines.svh"

module srec_line_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [srec_pkg::CHAR_W-1:0] in_char_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  out_status,
  output logic [srec_pkg::LINE_W-1:0] out_line_number
);
  import srec_pkg::*;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(logic [CHAR_W-1:0] c);
    hex_t              h;
    logic [CHAR_W-1:0] d;
    h = '0;
    d = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d    = c - CH_ZERO;
      h.ok = 1'b1;
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
      d    = c - HEX_UC_OFS;
      h.ok = 1'b1;
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
      d    = c - HEX_LC_OFS;
      h.ok = 1'b1;
    end
    h.val = d[3:0];
    return h;
  endfunction

  // input register
  logic              s1_valid_r;
  logic [CHAR_W-1:0] s1_char_r;

  // cross-line state
  logic [LINE_W-1:0] line_cnt_r, line_cnt_nxt;
  logic [LINE_W-1:0] tally_r, tally_nxt;
  fam_t              family_r, family_nxt;

  // current line state
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [7:0]        declared_r, declared_nxt;
  logic [7:0]        sum_r, sum_nxt;
  logic [7:0]        last_r, last_nxt;
  logic              hi_ok_r, hi_ok_nxt;
  logic [3:0]        hi_val_r, hi_val_nxt;
  logic [CHAR_W-1:0] type_r, type_nxt;
  logic [LINE_W-1:0] cfield_r, cfield_nxt;
  logic              start_ok_r, start_ok_nxt;
  logic              cnt_bad_r, cnt_bad_nxt;
  logic              pair_bad_r, pair_bad_nxt;

  // result register
  logic              out_valid_r;
  status_t           out_status_r;
  logic [LINE_W-1:0] out_line_r;

  logic              is_cr;
  logic              is_lf;
  logic              out_free;
  logic              s1_adv;
  logic              load_out;
  hex_t              hx;
  logic              pair_ok;
  logic [7:0]        pair_val;
  logic [POS_W-1:0]  pos_m3;
  logic [POS_W-2:0]  pair_idx;
  logic [7:0]        decl_eff;
  line_info_t        info;
  line_verdict_t     verdict;

  // handshake
  assign is_cr    = (s1_char_r == CH_CR);
  assign is_lf    = (s1_char_r == CH_LF);
  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && (!is_cr || out_free);
  assign load_out = s1_valid_r && is_cr && out_free;
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_char_r <= in_char_in;
    end
  end

  // pair decode
  assign hx       = hex_decode(s1_char_r);
  assign pair_ok  = hi_ok_r && hx.ok;
  assign pair_val = pair_ok ? {hi_val_r, hx.val} : 8'd0;
  assign pos_m3   = pos_r - 10'd3;
  assign pair_idx = pos_m3[POS_W-1:1];
  assign decl_eff = (pair_idx == '0) ? pair_val : declared_r;

  // end-of-line check
  assign info.start_ok    = start_ok_r;
  assign info.cnt_bad     = cnt_bad_r;
  assign info.pair_bad    = pair_bad_r;
  assign info.type_char   = type_r;
  assign info.char_pos    = pos_r;
  assign info.declared    = declared_r;
  assign info.byte_sum    = sum_r;
  assign info.last_byte   = last_r;
  assign info.count_field = cfield_r;
  assign info.line        = line_cnt_r;
  assign info.tally       = tally_r;
  assign info.family      = family_r;

  srec_status u_status (
    .info    (info),
    .verdict (verdict)
  );

  // per-character state update
  always_comb begin
    line_cnt_nxt = line_cnt_r;
    tally_nxt    = tally_r;
    family_nxt   = family_r;
    pos_nxt      = pos_r;
    declared_nxt = declared_r;
    sum_nxt      = sum_r;
    last_nxt     = last_r;
    hi_ok_nxt    = hi_ok_r;
    hi_val_nxt   = hi_val_r;
    type_nxt     = type_r;
    cfield_nxt   = cfield_r;
    start_ok_nxt = start_ok_r;
    cnt_bad_nxt  = cnt_bad_r;
    pair_bad_nxt = pair_bad_r;
    if (load_out) begin
      line_cnt_nxt = line_cnt_r + 16'd1;
      if (verdict.tally_inc) tally_nxt = tally_r + 16'd1;
      if (verdict.family_we) family_nxt = verdict.family;
      pos_nxt      = '0;
      declared_nxt = '0;
      sum_nxt      = '0;
      last_nxt     = '0;
      hi_ok_nxt    = 1'b0;
      hi_val_nxt   = '0;
      type_nxt     = '0;
      cfield_nxt   = '0;
      start_ok_nxt = 1'b0;
      cnt_bad_nxt  = 1'b0;
      pair_bad_nxt = 1'b0;
    end else if (s1_adv && !is_cr && !is_lf && pos_r != POS_MAX) begin
      pos_nxt = pos_r + 10'd1;
      if (pos_r == 10'd0) begin
        if (s1_char_r == CH_S) start_ok_nxt = 1'b1;
      end else if (pos_r == 10'd1) begin
        type_nxt = s1_char_r;
      end else if (!pos_r[0]) begin
        // first digit of a pair
        hi_ok_nxt  = hx.ok;
        hi_val_nxt = hx.ok ? hx.val : 4'd0;
      end else if (pair_idx == '0 && !pair_ok) begin
        cnt_bad_nxt = 1'b1;
      end else begin
        if (pair_idx == '0) declared_nxt = pair_val;
        if (pair_idx == 9'd1 && pair_ok) cfield_nxt[15:8] = pair_val;
        if (pair_idx == 9'd2 && pair_ok) cfield_nxt[7:0] = pair_val;
        if (pair_idx <= {1'b0, decl_eff}) begin
          if (!pair_ok) begin
            pair_bad_nxt = 1'b1;
          end else if (pair_idx < {1'b0, decl_eff}) begin
            sum_nxt = sum_r + pair_val;
          end else begin
            last_nxt = pair_val;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_cnt_r <= '0;
      tally_r    <= '0;
      family_r   <= FAM_S19;
      pos_r      <= '0;
      declared_r <= '0;
      sum_r      <= '0;
      last_r     <= '0;
      hi_ok_r    <= 1'b0;
      hi_val_r   <= '0;
      type_r     <= '0;
      cfield_r   <= '0;
      start_ok_r <= 1'b0;
      cnt_bad_r  <= 1'b0;
      pair_bad_r <= 1'b0;
    end else begin
      line_cnt_r <= line_cnt_nxt;
      tally_r    <= tally_nxt;
      family_r   <= family_nxt;
      pos_r      <= pos_nxt;
      declared_r <= declared_nxt;
      sum_r      <= sum_nxt;
      last_r     <= last_nxt;
      hi_ok_r    <= hi_ok_nxt;
      hi_val_r   <= hi_val_nxt;
      type_r     <= type_nxt;
      cfield_r   <= cfield_nxt;
      start_ok_r <= start_ok_nxt;
      cnt_bad_r  <= cnt_bad_nxt;
      pair_bad_r <= pair_bad_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= load_out;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r <= verdict.status;
      out_line_r   <= line_cnt_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_line_number = out_line_r;

  // checks
  `SREC_ASSERT_NEXT(a_line_advance, load_out, line_cnt_r == $past(line_cnt_r) + 16'd1, "line index did not advance on a finished line")
  `SREC_ASSERT_NEXT(a_line_number, load_out, out_valid && out_line_number == $past(line_cnt_r), "result line number does not match the finished line")
  `SREC_ASSERT_NEXT(a_line_clear, load_out, pos_r == '0 && !start_ok_r, "line state not cleared after carriage return")
  `SREC_ASSERT_SAME(a_stall_cause, !in_ready, s1_valid_r && is_cr && out_valid_r && !out_ready, "input stalled without a blocked carriage return")

endmodule

### tb/sv/srec_status_checker.sv
`timescale 1ns / 1ps

module srec_status_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [srec_pkg::CHAR_W-1:0] in_char_in,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [2:0]                  out_status,
  input  logic [srec_pkg::LINE_W-1:0] out_line_number,
  output int                          err_cnt,
  output int                          lines_pending
);
  import srec_pkg::*;

  typedef struct packed {
    status_t           status;
    logic [LINE_W-1:0] line_no;
  } line_result_t;

  // statuses of finished lines, oldest first
  line_result_t finished_lines[$];
  line_result_t want_r;

  // state carried across lines
  logic [LINE_W-1:0] line_idx;
  logic [LINE_W-1:0] s5_tally;
  fam_t              fam_seen;

  // state of the line being read
  logic [POS_W-1:0]  col;
  logic [7:0]        cnt_byte;
  logic [7:0]        sum_acc;
  logic [7:0]        cksum_byte;
  logic [4:0]        nib;
  logic [7:0]        rec_type;
  logic [LINE_W-1:0] count_val;
  logic              start_ok;
  logic              cnt_bad;
  logic              pair_bad;

  // bit 4 set when the character is a hex digit, low nibble its value
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [7:0] d;
    if (c >= CH_ZERO && c <= CH_NINE) d = c - CH_ZERO;
    else if (c >= CH_UPPER_A && c <= CH_UPPER_F) d = c - CH_UPPER_A + 8'd10;
    else if (c >= CH_LOWER_A && c <= CH_LOWER_F) d = c - CH_LOWER_A + 8'd10;
    else return 5'h00;
    return {1'b1, d[3:0]};
  endfunction

  task automatic clear_line();
    col = '0;
    cnt_byte = 8'h00;
    sum_acc = 8'h00;
    cksum_byte = 8'h00;
    nib = 5'h00;
    rec_type = 8'h00;
    count_val = '0;
    start_ok = 1'b0;
    cnt_bad = 1'b0;
    pair_bad = 1'b0;
  endtask

  // pair 0 is the count byte, pairs up to count-1 are summed, pair count is the checksum
  task automatic take_pair(input int k, input logic ok, input logic [7:0] val);
    if (k == 0 && !ok) begin
      cnt_bad = 1'b1;
      return;
    end
    if (k == 0) cnt_byte = val;
    if (k == 1 && ok) count_val[15:8] = val;
    if (k == 2 && ok) count_val[7:0] = val;
    if (k <= int'(cnt_byte)) begin
      if (!ok) pair_bad = 1'b1;
      else if (k < int'(cnt_byte)) sum_acc = sum_acc + val;
      else cksum_byte = val;
    end
  endtask

  // status of the line that a carriage return ends
  task automatic close_line(output status_t st);
    status_t           rel;
    fam_t              cur;
    logic [LINE_W-1:0] tally_want;
    rel = ST_OK;
    cur = FAM_S19;
    if (!start_ok) begin
      st = ST_START;
      return;
    end
    if (line_idx == 0 && rec_type != CH_ZERO) rel = ST_TYPE;
    if (line_idx != 0) begin
      case (rec_type)
        CH_ONE, CH_NINE:    cur = FAM_S19;
        CH_TWO, CH_EIGHT:   cur = FAM_S28;
        CH_THREE, CH_SEVEN: cur = FAM_S37;
        CH_FIVE, CH_SIX: begin
          tally_want = line_idx - 16'd1 - s5_tally;
          rel = (count_val != tally_want) ? ST_LINE_COUNT : ST_OK;
          s5_tally = s5_tally + 16'd1;
          cur = fam_seen;
        end
        default: begin
          rel = ST_TYPE;
          cur = FAM_S19;
        end
      endcase
      // a family change outranks type and count errors
      if (line_idx > 1 && cur != fam_seen) rel = ST_CONFLICT;
      else fam_seen = cur;
    end
    if (rel != ST_OK) st = rel;
    else if (col < 4 || cnt_bad) st = ST_HEX;
    else if (int'(col) - 4 != 2 * int'(cnt_byte)) st = ST_BYTE_COUNT;
    else if (pair_bad) st = ST_HEX;
    else if (cksum_byte != ~sum_acc) st = ST_CHECKSUM;
    else st = ST_OK;
  endtask

  // one accepted character
  task automatic take_char(input logic [7:0] c);
    logic [4:0]   h;
    logic         ok;
    logic [7:0]   val;
    status_t      st;
    line_result_t r;
    if (c == CH_LF) return;
    if (c == CH_CR) begin
      close_line(st);
      r.status = st;
      r.line_no = line_idx;
      finished_lines.push_back(r);
      line_idx = line_idx + 16'd1;
      clear_line();
      return;
    end
    if (col < POS_MAX) begin
      if (col == 0) begin
        if (c == CH_S) start_ok = 1'b1;
      end else if (col == 1) begin
        rec_type = c;
      end else begin
        h = hex_nibble(c);
        if (!col[0]) begin
          nib = h;
        end else begin
          ok = nib[4] & h[4];
          val = ok ? {nib[3:0], h[3:0]} : 8'h00;
          take_pair((int'(col) - 3) >> 1, ok, val);
        end
      end
      col = col + 1'b1;
    end
  endtask

  // predict on each taken character, compare each taken result
  always @(posedge clk) begin
    if (!rst_n) begin
      line_idx = '0;
      s5_tally = '0;
      fam_seen = FAM_S19;
      clear_line();
      finished_lines.delete();
    end else begin
      if (in_valid && in_ready) take_char(in_char_in);
      if (out_valid && out_ready) begin
        if (finished_lines.size() == 0) begin
          $error("result with no line pending: status %0d line %0d",
                 out_status, out_line_number);
          err_cnt++;
        end else begin
          want_r = finished_lines.pop_front();
          if (out_status !== want_r.status) begin
            $error("out_status: expected %0d, got %0d", want_r.status, out_status);
            err_cnt++;
          end
          if (out_line_number !== want_r.line_no) begin
            $error("out_line_number: expected %0d, got %0d", want_r.line_no,
                   out_line_number);
            err_cnt++;
          end
        end
      end
    end
    lines_pending = finished_lines.size();
  end

endmodule

### tb/sv/srec_line_checker_tb.sv
`timescale 1ns / 1ps

module srec_line_checker_tb;
  import srec_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_CHARS = 220;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [CHAR_W-1:0]   in_char_in = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [2:0]          out_status;
  logic [LINE_W-1:0]   out_line_number;

  int err_cnt;
  int lines_pending;
  int cycle_cnt = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int chars_sent = 0;
  int target;

  // just enough of the line history to aim S5/S6 counts
  int          lines_sent = 0;
  int          s5_sent = 0;
  int          chars_in_line = 0;
  logic [7:0]  first_c = 8'h00;
  logic [7:0]  type_c = 8'h00;

  fam_t        main_fam;
  logic [7:0]  line_buf[$];
  logic [7:0]  payload_q[$];

  srec_line_checker u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_char_in      (in_char_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_line_number (out_line_number)
  );

  srec_status_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_char_in      (in_char_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_line_number (out_line_number),
    .err_cnt         (err_cnt),
    .lines_pending   (lines_pending)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // result side backpressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_UPPER_A && c <= CH_UPPER_F) ||
           (c >= CH_LOWER_A && c <= CH_LOWER_F);
  endfunction

  // any character that stays inside a line
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_CR || c == CH_LF);
    return c;
  endfunction

  function automatic logic [7:0] pick_non_hex();
    logic [7:0] c;
    do c = plain_char(); while (is_hex(c));
    return c;
  endfunction

  // digits in either case
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] base;
    if (n < 4'd10) return CH_ZERO + n;
    base = $urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A;
    return base + n - 8'd10;
  endfunction

  function automatic logic [7:0] type_of(input fam_t fam, input bit term);
    case (fam)
      FAM_S19: return term ? CH_NINE : CH_ONE;
      FAM_S28: return term ? CH_EIGHT : CH_TWO;
      default: return term ? CH_SEVEN : CH_THREE;
    endcase
  endfunction

  task automatic add_byte(input logic [7:0] b);
    line_buf.push_back(hex_char(b[7:4]));
    line_buf.push_back(hex_char(b[3:0]));
  endtask

  task automatic random_payload(input int n);
    payload_q.delete();
    repeat (n) payload_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // S5/S6 payload: data lines so far, optionally off by one bit
  task automatic count_payload(input bit off);
    logic [15:0] tally_want;
    tally_want = 16'(lines_sent - 1 - s5_sent);
    if (off) tally_want = tally_want ^ 16'(1 << $urandom_range(0, 15));
    payload_q.delete();
    payload_q.push_back(tally_want[15:8]);
    payload_q.push_back(tally_want[7:0]);
  endtask

  // well-formed record from payload_q, checksum xored with flip
  task automatic build_record(input logic [7:0] rtype, input logic [7:0] flip);
    logic [7:0] sum;
    line_buf.delete();
    line_buf.push_back(CH_S);
    line_buf.push_back(rtype);
    sum = 8'(payload_q.size() + 1);
    add_byte(sum);
    foreach (payload_q[i]) begin
      sum = sum + payload_q[i];
      add_byte(payload_q[i]);
    end
    add_byte(~sum ^ flip);
  endtask

  // one character request, with random idle cycles before it
  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_char_in <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (c != CH_LF) chars_sent++;
    if (c == CH_CR) begin
      if (first_c == CH_S && lines_sent != 0 && (type_c == CH_FIVE || type_c == CH_SIX))
        s5_sent++;
      lines_sent++;
      chars_in_line = 0;
      first_c = 8'h00;
      type_c = 8'h00;
    end else if (c != CH_LF) begin
      if (chars_in_line == 0) first_c = c;
      else if (chars_in_line == 1) type_c = c;
      if (chars_in_line < 2) chars_in_line++;
    end
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_char(line_buf[i]);
    send_char(CH_CR);
  endtask

  // stop sending until every line status has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (lines_pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // mostly records of the run's family, some counts, conflicts, flaws and noise
  task automatic random_line();
    int         pick;
    int         flaw;
    int         cut;
    logic [7:0] rt;
    logic [7:0] flip;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    flaw = $urandom_range(0, 99);
    flip = 8'h00;
    if (pick < 8) begin
      line_buf.delete();
      repeat ($urandom_range(0, 12)) line_buf.push_back(8'($urandom_range(0, 255)));
      send_line();
      return;
    end
    if (pick < 20) begin
      rt = $urandom_range(0, 1) ? CH_FIVE : CH_SIX;
      count_payload($urandom_range(0, 3) == 0);
    end else begin
      if (pick < 25)
        rt = type_of(fam_t'((int'(main_fam) + $urandom_range(1, 2)) % 3),
                     $urandom_range(0, 1) == 0);
      else if (pick < 28) rt = plain_char();
      else rt = type_of(main_fam, $urandom_range(0, 4) == 0);
      random_payload($urandom_range(0, 16));
    end
    if (flaw >= 70 && flaw % 8 == 1) flip = 8'($urandom_range(1, 255));
    build_record(rt, flip);
    if (flaw >= 70) begin
      case (flaw % 8)
        0: begin
          do c = plain_char(); while (c == CH_S);
          line_buf[0] = c;
        end
        2: line_buf[$urandom_range(2, line_buf.size() - 1)] = pick_non_hex();
        3: repeat ($urandom_range(1, 2)) void'(line_buf.pop_back());
        4: add_byte(8'($urandom_range(0, 255)));
        5: begin
          cut = $urandom_range(0, 4);
          while (line_buf.size() > cut) void'(line_buf.pop_back());
        end
        6: line_buf.insert($urandom_range(0, line_buf.size()), CH_LF);
        7: line_buf[$urandom_range(2, 3)] = pick_non_hex();
        default: ;
      endcase
    end
    send_line();
  endtask

  initial begin
    main_fam = fam_t'($urandom_range(0, 2));
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // header line, usually S0
    random_payload(4);
    build_record(($urandom_range(0, 3) != 0) ? CH_ZERO : type_of(main_fam, 1'b0), 8'h00);
    send_line();
    // first data line fixes the family, stray line feed inside
    random_payload(4);
    build_record(type_of(main_fam, 1'b0), 8'h00);
    line_buf.insert(5, CH_LF);
    send_line();
    // extreme data bytes
    payload_q = '{8'h00, 8'hFF, 8'h00, 8'hFF};
    build_record(type_of(main_fam, 1'b1), 8'h00);
    send_line();
    // count records, matching then wrong
    count_payload(1'b0);
    build_record(CH_FIVE, 8'h00);
    send_line();
    count_payload(1'b1);
    build_record(CH_SIX, 8'h00);
    send_line();
    // lowercase start
    random_payload(2);
    build_record(type_of(main_fam, 1'b0), 8'h00);
    line_buf[0] = 8'h73;
    send_line();
    // invalid record type
    build_record(8'h34, 8'h00);
    send_line();
    // family conflict
    build_record(type_of(fam_t'((int'(main_fam) + 1) % 3), 1'b0), 8'h00);
    send_line();
    // count byte not hex
    build_record(type_of(main_fam, 1'b0), 8'h00);
    line_buf[3] = 8'h47;
    send_line();
    // one character short
    build_record(type_of(main_fam, 1'b0), 8'h00);
    void'(line_buf.pop_back());
    send_line();
    // bad digit in the data
    build_record(type_of(main_fam, 1'b0), 8'h00);
    line_buf[5] = 8'h2E;
    send_line();
    // checksum off by one
    build_record(type_of(main_fam, 1'b0), 8'h01);
    send_line();
    // zero count, the count byte becomes its own checksum
    line_buf = '{CH_S, type_of(main_fam, 1'b0), CH_ZERO, CH_ZERO};
    send_line();
    // short lines
    line_buf.delete();
    send_line();
    line_buf = '{CH_S};
    send_line();
    line_buf = '{CH_S, type_of(main_fam, 1'b0)};
    send_line();
    line_buf = '{CH_S, type_of(main_fam, 1'b0), CH_UPPER_F};
    send_line();
    // largest count byte on a short line
    line_buf = '{CH_S, type_of(main_fam, 1'b0), CH_UPPER_F, CH_UPPER_F};
    add_byte(8'h5A);
    send_line();
    drain();

    // random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 48; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 48; end
        default: begin idle_pct = 35; stall_pct = 35; end
      endcase
      target = chars_sent + PHASE_CHARS;
      while (chars_sent < target) random_line();
      drain();
    end

    repeat (10) @(negedge clk);
    if (err_cnt == 0 && lines_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
